@@ design/lfss_pkg.sv @@
// Shared types and constants for the LED frame scan serializer.
package lfss_pkg;

  // Input command codes carried in tuser.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Width of the command field.
  localparam int unsigned CMD_W = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_en;        // Read the next frame word from the store.
    logic do_tick;      // Advance the pin sequence by one phase.
    logic do_append;    // Append the input word to the store.
    logic do_clear;     // Drop all frames and restart the scan.
    logic load_result;  // Capture the result into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic store_empty;  // No frame words are held.
    logic phase_zero;   // The next tick starts a new frame.
  } status_t;

endpackage

@@ design/led_frame_scan_serializer_core.sv @@
// Top level of the LED frame scan serializer.
// The block holds up to MAX_FRAMES frame words of CHAIN_BITS bits and drives a serial-in,
// latched shift-register chain one pin phase per tick command: for each bit, MSB first, the
// data line is set with the shift clock low, then the shift clock rises; after the last bit
// the latch clock falls and then rises. Frames repeat in store order, or reversed when
// the scan_reverse register (cfg_wdata_i written with cfg_we_i) is 1. Each transfer in
// gives exactly one transfer out. A tick that starts a frame first fetches its frame word
// out of the store RAM through its registered read port, in a fetch state of its own.
// The store is not cleared after reset, so the block is ready at once; appends to a full
// store are dropped and flagged.
module led_frame_scan_serializer_core #(
  parameter int unsigned MAX_FRAMES = 1024,
  parameter int unsigned CHAIN_BITS = 18
) (
  input  logic clk_i,
  input  logic rst_ni,

  // Configuration: scan_reverse.
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,

  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: frame_word, zero padded to whole bytes.
  input  logic [((CHAIN_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // tuser: command.
  input  logic [lfss_pkg::CMD_W-1:0]            s_axis_tuser,

  // Output stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: data_pin, shift_clock, latch_clock, stored_frames, append_dropped,
  // zero padded to whole bytes.
  output logic [(($clog2(MAX_FRAMES + 1) + 4 + 7) / 8) * 8-1:0] m_axis_tdata
);

  import lfss_pkg::*;

  localparam int unsigned RES_W = $clog2(MAX_FRAMES + 1) + 4;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  cmd_t             cmd;
  status_t          status;
  logic [RES_W-1:0] result;

  lfss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfss_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .CHAIN_BITS (CHAIN_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .frame_word_i (s_axis_tdata[CHAIN_BITS-1:0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .result_o     (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

@@ design/lfss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lfss_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lfss_ctrl.sv @@
// Controller state machine: input and output handshakes and command sequencing.
module lfss_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lfss_pkg::CMD_W-1:0]      command_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  lfss_pkg::status_t               status_i,
  output lfss_pkg::cmd_t                  cmd_o
);

  import lfss_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic needs_fetch;

  // An item is taken when idle and the output register is free or draining.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // A tick that opens a frame first reads its word from the store.
  assign needs_fetch = (command_i == CMD_TICK) && !status_i.store_empty &&
                       status_i.phase_zero;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (needs_fetch) begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_FETCH;
          end else begin
            cmd_o.load_result = 1'b1;
            case (command_i)
              CMD_TICK:   cmd_o.do_tick   = 1'b1;
              CMD_APPEND: cmd_o.do_append = 1'b1;
              CMD_CLEAR:  cmd_o.do_clear  = 1'b1;
              default:    ;
            endcase
          end
        end
      end
      ST_FETCH: begin
        cmd_o.do_tick     = 1'b1;
        cmd_o.load_result = 1'b1;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid follows loads and completed transfers.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/lfss_datapath.sv @@
// Datapath: frame store, scan counters, shift word, pin levels and result register.
module lfss_datapath #(
  parameter int unsigned MAX_FRAMES = 1024,
  parameter int unsigned CHAIN_BITS = 18
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic [CHAIN_BITS-1:0]                frame_word_i,
  input  lfss_pkg::cmd_t                       cmd_i,
  output lfss_pkg::status_t                    status_o,
  output logic [$clog2(MAX_FRAMES+1)+3:0]      result_o
);

  import lfss_pkg::*;

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FRAME_PHASES = 2 * CHAIN_BITS + 2;
  localparam int unsigned PW = $clog2(FRAME_PHASES);
  localparam logic [PW-1:0] LATCH_LOW_PHASE = PW'(2 * CHAIN_BITS);
  localparam logic [PW-1:0] LAST_PHASE      = PW'(FRAME_PHASES - 1);
  localparam logic [CW-1:0] FULL_COUNT      = CW'(MAX_FRAMES);

  logic                  reverse_q;
  logic [CW-1:0]         total_q, total_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [PW-1:0]         phase_q, phase_d;
  logic [CHAIN_BITS-1:0] shift_q, shift_d;
  logic                  data_q, data_d;
  logic                  sclk_q, sclk_d;
  logic                  latch_q, latch_d;
  logic                  store_full;
  logic                  dropped;
  logic [CW-1:0]         rev_idx;
  logic [AW-1:0]         rd_addr;
  logic [CHAIN_BITS-1:0] rd_data;
  logic [CHAIN_BITS-1:0] cur_word;
  logic [CW-1:0]         pos_next;
  logic [CW+3:0]         result_q;

  assign store_full = (total_q == FULL_COUNT);
  assign dropped    = cmd_i.do_append && store_full;

  // Frame address counted from the chosen end of the store.
  assign rev_idx = total_q - CW'(1) - CW'(pos_q);
  assign rd_addr = reverse_q ? rev_idx[AW-1:0] : pos_q;

  lfss_ram #(
    .WIDTH (CHAIN_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_append && !store_full),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i (frame_word_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // A new frame takes its word from the store, later phases from the shifter.
  assign cur_word = (phase_q == '0) ? rd_data : shift_q;
  assign pos_next = CW'(pos_q) + CW'(1);

  // Pin sequence and store bookkeeping.
  always_comb begin
    total_d = total_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    shift_d = shift_q;
    data_d  = data_q;
    sclk_d  = sclk_q;
    latch_d = latch_q;
    if (cmd_i.do_tick && (total_q != '0)) begin
      if (phase_q < LATCH_LOW_PHASE) begin
        if (!phase_q[0]) begin
          data_d  = cur_word[CHAIN_BITS-1];
          shift_d = cur_word << 1;
          sclk_d  = 1'b0;
        end else begin
          sclk_d = 1'b1;
        end
        phase_d = phase_q + PW'(1);
      end else if (phase_q == LATCH_LOW_PHASE) begin
        latch_d = 1'b0;
        phase_d = LAST_PHASE;
      end else begin
        latch_d = 1'b1;
        phase_d = '0;
        pos_d   = (pos_next >= total_q) ? '0 : pos_next[AW-1:0];
      end
    end
    if (cmd_i.do_append && !store_full) begin
      total_d = total_q + CW'(1);
    end
    if (cmd_i.do_clear) begin
      total_d = '0;
      pos_d   = '0;
      phase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
      total_q   <= '0;
      pos_q     <= '0;
      phase_q   <= '0;
      shift_q   <= '0;
      data_q    <= 1'b0;
      sclk_q    <= 1'b0;
      latch_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reverse_q <= cfg_wdata_i;
      end
      total_q <= total_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      data_q  <= data_d;
      sclk_q  <= sclk_d;
      latch_q <= latch_d;
    end
  end

  // Result register: pins, frame count and the drop flag after this item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      result_q <= {dropped, total_d, latch_d, sclk_d, data_d};
    end
  end

  assign result_o             = result_q;
  assign status_o.store_empty = (total_q == '0);
  assign status_o.phase_zero  = (phase_q == '0);

endmodule

@@ tb/tb_led_frame_scan_serializer_core.sv @@
// Self-checking testbench for the LED frame scan serializer core.
`timescale 1ns / 100ps

module tb_led_frame_scan_serializer_core;
  import lfss_pkg::*;

  localparam int unsigned MAX_FRAMES   = 1024;
  localparam int unsigned CHAIN_BITS   = 18;
  localparam int unsigned FRAME_PHASES = 2 * CHAIN_BITS + 2;

  // The one command code that the package does not name: the block ignores it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One output transfer, fields listed from the highest bit down.
  typedef struct packed {
    logic        append_dropped;
    logic [10:0] stored_frames;
    logic        latch_clock;
    logic        shift_clock;
    logic        data_pin;
  } pin_report_t;

  // Predicts the pin levels and store state and checks each output transfer in order.
  class scan_scoreboard;
    logic [CHAIN_BITS-1:0] frames [MAX_FRAMES];
    int unsigned           total = 0;
    int unsigned           position = 0;
    int unsigned           phase = 0;
    logic [CHAIN_BITS-1:0] shift_word = '0;
    logic                  data_pin = 1'b0;
    logic                  shift_clock = 1'b0;
    logic                  latch_clock = 1'b0;
    logic                  reverse = 1'b0;
    int unsigned           errors = 0;
    pin_report_t           pending_reports [$];

    // Moves the serial pin sequence on by one phase.
    function void advance_phase();
      int unsigned idx;
      if (total == 0) return;
      if (position >= total) position = 0;
      if (phase >= FRAME_PHASES) phase = 0;
      if (phase == 0) begin
        idx = reverse ? (total - 1 - position) : position;
        shift_word = frames[idx];
      end
      if (phase < 2 * CHAIN_BITS) begin
        if (phase % 2 == 0) begin
          data_pin = shift_word[CHAIN_BITS-1];
          shift_word = shift_word << 1;
          shift_clock = 1'b0;
        end else begin
          shift_clock = 1'b1;
        end
        phase++;
      end else if (phase == 2 * CHAIN_BITS) begin
        latch_clock = 1'b0;
        phase++;
      end else begin
        latch_clock = 1'b1;
        phase = 0;
        position++;
        if (position >= total) position = 0;
      end
    endfunction

    // Applies one accepted input transfer and queues the report it should produce.
    function void note_input(logic [CMD_W-1:0] cmd, logic [CHAIN_BITS-1:0] word);
      pin_report_t report;
      report.append_dropped = 1'b0;
      case (cmd)
        CMD_TICK: advance_phase();
        CMD_APPEND: begin
          if (total < MAX_FRAMES) begin
            frames[total] = word;
            total++;
          end else begin
            report.append_dropped = 1'b1;
          end
        end
        CMD_CLEAR: begin
          total = 0;
          position = 0;
          phase = 0;
        end
        default: ;
      endcase
      report.data_pin = data_pin;
      report.shift_clock = shift_clock;
      report.latch_clock = latch_clock;
      report.stored_frames = total[10:0];
      pending_reports.push_back(report);
    endfunction

    // Compares one output transfer with the oldest pending report.
    function void check_result(logic [15:0] tdata);
      pin_report_t got;
      pin_report_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected output transfer: tdata %h", tdata);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      got = pin_report_t'(tdata[14:0]);
      if (got.data_pin !== want.data_pin) begin
        $error("data_pin: expected %0d, got %0d", want.data_pin, got.data_pin);
        errors++;
      end
      if (got.shift_clock !== want.shift_clock) begin
        $error("shift_clock: expected %0d, got %0d", want.shift_clock, got.shift_clock);
        errors++;
      end
      if (got.latch_clock !== want.latch_clock) begin
        $error("latch_clock: expected %0d, got %0d", want.latch_clock, got.latch_clock);
        errors++;
      end
      if (got.stored_frames !== want.stored_frames) begin
        $error("stored_frames: expected %0d, got %0d", want.stored_frames, got.stored_frames);
        errors++;
      end
      if (got.append_dropped !== want.append_dropped) begin
        $error("append_dropped: expected %0d, got %0d", want.append_dropped,
               got.append_dropped);
        errors++;
      end
      if (tdata[15] !== 1'b0) begin
        $error("tdata padding: expected 0, got %0d", tdata[15]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = CMD_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;

  scan_scoreboard board;

  led_frame_scan_serializer_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .CHAIN_BITS(CHAIN_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Output side: check every completed transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one command, with a random gap first, and waits for its transfer.
  task automatic offer_command(input logic [CMD_W-1:0] cmd,
                               input logic [CHAIN_BITS-1:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {6'd0, word};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(cmd, word);
  endtask

  // Stops offering and waits until every pending report has come back.
  task automatic wait_for_reports();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the scan direction register; only called while the block is idle.
  task automatic set_scan_direction(input logic rev);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= rev;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.reverse = rev;
  endtask

  function automatic logic [CHAIN_BITS-1:0] random_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return CHAIN_BITS'($urandom);
    endcase
  endfunction

  // Mostly ticks over a small store, with appends, clears and unused codes mixed in.
  task automatic scan_traffic(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(999);
      if (board.total == 0 && r >= 50) begin
        offer_command(CMD_APPEND, random_word());
      end else if (r < 5) begin
        offer_command(CMD_CLEAR, random_word());
      end else if (r < 25) begin
        offer_command(CMD_UNUSED, random_word());
      end else if (r < 60 && board.total < 5) begin
        offer_command(CMD_APPEND, random_word());
      end else begin
        offer_command(CMD_TICK, random_word());
      end
    end
  endtask

  // One traffic phase with its own idle rates and scan direction.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input logic rev, input int unsigned count);
    wait_for_reports();
    set_scan_direction(rev);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    scan_traffic(count);
  endtask

  // Stimulus sequence.
  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_scan_direction(1'b0);

    // Directed: empty store, unused code, extreme words, clear mid-frame.
    offer_command(CMD_TICK, '0);
    offer_command(CMD_UNUSED, '1);
    offer_command(CMD_CLEAR, 18'h15555);
    offer_command(CMD_APPEND, 18'h3FFFF);
    offer_command(CMD_APPEND, 18'h00000);
    offer_command(CMD_APPEND, 18'h2AAAA);
    repeat (6) offer_command(CMD_TICK, '0);
    offer_command(CMD_UNUSED, '0);
    offer_command(CMD_APPEND, 18'h15555);
    repeat (3) offer_command(CMD_TICK, '1);
    offer_command(CMD_CLEAR, '0);
    offer_command(CMD_TICK, '0);
    offer_command(CMD_APPEND, 18'h20001);
    repeat (4) offer_command(CMD_TICK, '0);

    // Random phases with different idle patterns and directions.
    run_phase(0, 0, 1'b0, 200);
    run_phase(81, 0, 1'b1, 200);

    // Long receiver hold-off while the sender keeps offering.
    wait_for_reports();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    scan_traffic(80);

    run_phase(0, 81, 1'b0, 200);
    run_phase(19, 19, 1'b1, 200);

    // Fill the store past its limit, then scan from the far end and clear.
    wait_for_reports();
    set_scan_direction(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    offer_command(CMD_CLEAR, '0);
    repeat (MAX_FRAMES + 2) offer_command(CMD_APPEND, random_word());
    offer_command(CMD_UNUSED, '0);
    repeat (FRAME_PHASES + 2) offer_command(CMD_TICK, '0);
    offer_command(CMD_CLEAR, '0);
    offer_command(CMD_TICK, '0);

    wait_for_reports();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
